@@ sv/assert_macros.svh @@
// assertion helpers included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SBMQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next, outside reset
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sbmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_pkg
// types and codes of the shared buffer multi queue
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int QIDX_W = 3;
    localparam int DATA_W = 32;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                     cmd;
        logic [QIDX_W-1:0]        queue_index;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic                     queue_empty;
        logic                     store_full;
    } out_t;

endpackage

@@ sv/shared_buffer_multi_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_top
// fifo queues sharing one slot store through linked lists and a free list
// ----------------------------------------------------------------------------
// channel | ports                    | beat
// input   | s_valid s_ready s_data   | cmd, queue_index, value
// result  | m_valid m_ready m_data   | status, read_value, queue_empty, store_full
//
// per beat, the link and data rams are read in the accept cycle, the
// result and all write-backs follow in the next cycle
// a new beat is taken once no beat is in work and the result register is free or being drained
// reset clears the list pointers at once; link entries at or above the
// allocation mark read as the initial chain, so no clearing pass is needed
// a stalled result holds the block after its working cycle
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_top #(
    parameter int SLOTS  = 64,
    parameter int QUEUES = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sbmq_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sbmq_pkg::out_t m_data
);
    import sbmq_pkg::*;

    `include "assert_macros.svh"

    localparam int LW     = $clog2(SLOTS + 1);
    localparam int AW     = $clog2(SLOTS);
    localparam int QDEPTH = (QUEUES < (1 << QIDX_W)) ? QUEUES : (1 << QIDX_W);
    localparam int QW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [LW-1:0] NULL_PTR = LW'(SLOTS);

    logic              busy_reg, busy_next;
    logic              m_valid_reg, m_valid_next;
    out_t              out_reg, out_next;
    logic              cmd_reg;
    logic [QW-1:0]     qsel_reg;
    logic              qok_reg;
    logic [DATA_W-1:0] value_reg;
    logic [AW-1:0]     link_addr_reg;
    logic [LW-1:0]     free_head_reg, free_head_next;
    logic [LW-1:0]     hwm_reg, hwm_next;
    logic [LW-1:0]     head_reg [QDEPTH];
    logic [LW-1:0]     head_next [QDEPTH];
    logic [LW-1:0]     tail_reg [QDEPTH];
    logic [LW-1:0]     tail_next [QDEPTH];

    logic              s_fire;
    logic              qok;
    logic [QW-1:0]     qsel;
    logic [AW-1:0]     link_raddr;
    logic [AW-1:0]     data_raddr;
    logic [LW-1:0]     link_q;
    logic [LW-1:0]     link_rd;
    logic [DATA_W-1:0] data_q;

    logic              link_we;
    logic [AW-1:0]     link_waddr;
    logic [LW-1:0]     link_wdata;
    logic              data_we;
    logic [AW-1:0]     data_waddr;

    logic [LW-1:0]     cur_head;
    logic [LW-1:0]     cur_tail;

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // read issue in the accept cycle
    always_comb begin
        qok  = int'(s_data.queue_index) < QUEUES;
        qsel = qok ? s_data.queue_index[QW-1:0] : '0;
        if (s_data.cmd == CMD_ENQ) begin
            link_raddr = free_head_reg[AW-1:0];
        end else begin
            link_raddr = head_reg[qsel][AW-1:0];
        end
        data_raddr = head_reg[qsel][AW-1:0];
    end

    sbmq_ram #(
        .WIDTH(LW),
        .DEPTH(SLOTS)
    ) u_link_ram (
        .aclk (aclk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .re   (s_fire),
        .raddr(link_raddr),
        .rdata(link_q)
    );

    sbmq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(SLOTS)
    ) u_data_ram (
        .aclk (aclk),
        .we   (data_we),
        .waddr(data_waddr),
        .wdata(value_reg),
        .re   (s_fire),
        .raddr(data_raddr),
        .rdata(data_q)
    );

    // never-allocated slots read as the reset chain
    assign link_rd = (LW'(link_addr_reg) >= hwm_reg) ? (LW'(link_addr_reg) + LW'(1)) : link_q;
    assign cur_head = head_reg[qsel_reg];
    assign cur_tail = tail_reg[qsel_reg];

    always_comb begin
        busy_next      = busy_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        link_we        = 1'b0;
        link_waddr     = '0;
        link_wdata     = '0;
        data_we        = 1'b0;
        data_waddr     = free_head_reg[AW-1:0];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            busy_next = 1'b1;
        end

        if (busy_reg) begin
            busy_next           = 1'b0;
            m_valid_next        = 1'b1;
            out_next.status     = ST_DONE;
            out_next.read_value = '0;
            out_next.queue_empty = 1'b1;
            if (!qok_reg) begin
                out_next.status = (cmd_reg == CMD_ENQ) ? ST_FULL : ST_EMPTY;
            end else if (cmd_reg == CMD_ENQ) begin
                if (free_head_reg == NULL_PTR) begin
                    out_next.status      = ST_FULL;
                    out_next.queue_empty = (cur_tail == NULL_PTR);
                end else begin
                    free_head_next = link_rd;
                    data_we        = 1'b1;
                    if (free_head_reg == hwm_reg) begin
                        hwm_next = hwm_reg + LW'(1);
                    end
                    if (cur_tail == NULL_PTR) begin
                        head_next[qsel_reg] = free_head_reg;
                    end else begin
                        link_we    = 1'b1;
                        link_waddr = cur_tail[AW-1:0];
                        link_wdata = free_head_reg;
                    end
                    tail_next[qsel_reg]  = free_head_reg;
                    out_next.queue_empty = 1'b0;
                end
            end else begin
                if (cur_tail == NULL_PTR || cur_head == NULL_PTR) begin
                    out_next.status = ST_EMPTY;
                end else begin
                    out_next.read_value = data_q;
                    if (cur_head == cur_tail) begin
                        head_next[qsel_reg]  = NULL_PTR;
                        tail_next[qsel_reg]  = NULL_PTR;
                        out_next.queue_empty = 1'b1;
                    end else begin
                        head_next[qsel_reg]  = link_rd;
                        out_next.queue_empty = 1'b0;
                    end
                    link_we        = 1'b1;
                    link_waddr     = cur_head[AW-1:0];
                    link_wdata     = free_head_reg;
                    free_head_next = cur_head;
                end
            end
            out_next.store_full = (free_head_next == NULL_PTR);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            for (int i = 0; i < QDEPTH; i++) begin
                head_reg[i] <= NULL_PTR;
                tail_reg[i] <= NULL_PTR;
            end
        end else begin
            busy_reg      <= busy_next;
            m_valid_reg   <= m_valid_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_fire) begin
            cmd_reg       <= s_data.cmd;
            qsel_reg      <= qsel;
            qok_reg       <= qok;
            value_reg     <= s_data.value;
            link_addr_reg <= link_raddr;
        end
    end

    `SBMQ_ASSERT_NEXT(a_accept_busy, s_fire, busy_reg && !s_ready, "accept did not start work")
    `SBMQ_ASSERT_NEXT(a_busy_result, busy_reg, m_valid_reg && !busy_reg, "work gave no result")
    `SBMQ_ASSERT(a_busy_out_free, !(busy_reg && m_valid_reg), "result register busy during work")
    `SBMQ_ASSERT(a_ptr_range, free_head_reg <= NULL_PTR && hwm_reg <= NULL_PTR, "pointer out of range")

endmodule

@@ sv/sbmq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbmq_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks shared_buffer_multi_queue_top against a software copy of the slot
// store and its linked lists: directed corner beats, random traffic under a long
// result hold-off, then random traffic shaped to fill and drain the store under
// four phases of input idling and result stalls, and a full drain pause
// ----------------------------------------------------------------------------
module testbench;
    import sbmq_pkg::*;

    localparam int          SLOT_COUNT   = 64;
    localparam int          QUEUE_COUNT  = 8;
    localparam logic [6:0]  NO_SLOT      = 7'(SLOT_COUNT);
    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 9;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          PHASE_BEATS  = 375;
    localparam int          BLOCK_BEATS  = 75;
    localparam longint      TIMEOUT_NS   = 2_000_000;

    class queue_scoreboard;
        logic [31:0] slot_data [SLOT_COUNT];
        logic [6:0]  slot_link [SLOT_COUNT];
        logic [6:0]  head [QUEUE_COUNT];
        logic [6:0]  tail [QUEUE_COUNT];
        logic [6:0]  free_head;
        out_t        expected_q [$];
        int          mismatches;
        int          checked;
        int          dropped;
        int          empty_reads;

        function new();
            for (int s = 0; s < SLOT_COUNT; s++) begin
                slot_data[s] = '0;
                slot_link[s] = 7'(s + 1);
            end
            slot_link[SLOT_COUNT-1] = NO_SLOT;
            for (int q = 0; q < QUEUE_COUNT; q++) begin
                head[q] = NO_SLOT;
                tail[q] = NO_SLOT;
            end
            free_head = '0;
        endfunction

        function void note_input(in_t beat);
            out_t       exp;
            logic [6:0] slot;
            int         q;
            q   = int'(beat.queue_index);
            exp = '0;
            if (q >= QUEUE_COUNT) begin
                exp.status = (beat.cmd == CMD_ENQ) ? ST_FULL : ST_EMPTY;
            end else if (beat.cmd == CMD_ENQ) begin
                if (free_head == NO_SLOT) begin
                    exp.status = ST_FULL;
                end else begin
                    slot            = free_head;
                    free_head       = slot_link[slot];
                    slot_data[slot] = beat.value;
                    if (tail[q] == NO_SLOT) begin
                        head[q] = slot;
                    end else begin
                        slot_link[tail[q]] = slot;
                    end
                    tail[q] = slot;
                end
            end else begin
                if (tail[q] == NO_SLOT || head[q] == NO_SLOT) begin
                    exp.status = ST_EMPTY;
                end else begin
                    slot           = head[q];
                    exp.read_value = slot_data[slot];
                    if (slot == tail[q]) begin
                        head[q] = NO_SLOT;
                        tail[q] = NO_SLOT;
                    end else begin
                        head[q] = slot_link[slot];
                    end
                    slot_link[slot] = free_head;
                    free_head       = slot;
                end
            end
            if (q >= QUEUE_COUNT) begin
                exp.queue_empty = 1'b1;
            end else begin
                exp.queue_empty = (tail[q] == NO_SLOT);
            end
            exp.store_full = (free_head == NO_SLOT);
            if (exp.status == ST_FULL) dropped++;
            if (exp.status == ST_EMPTY) empty_reads++;
            expected_q.push_back(exp);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(out_t got);
            out_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing expected", got));
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got !== exp) begin
                report_mismatch($sformatf(
                    "beat %0d: status %0d value %h empty %b full %b, expected %0d %h %b %b",
                    checked, got.status, got.read_value, got.queue_empty, got.store_full,
                    exp.status, exp.read_value, exp.queue_empty, exp.store_full));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic            aclk    = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_t             s_data  = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_t            m_data;

    int              idle_pct  = 0;
    int              stall_pct = 0;
    int              hold_left = 0;
    queue_scoreboard sb;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    shared_buffer_multi_queue_top #(
        .SLOTS  (SLOT_COUNT),
        .QUEUES (QUEUE_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    task automatic send_beat(input in_t beat);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(beat);
    endtask

    task automatic send_op(input logic cmd, input logic [2:0] q, input logic [31:0] v);
        in_t beat;
        beat.cmd         = cmd;
        beat.queue_index = q;
        beat.value       = v;
        send_beat(beat);
    endtask

    // traffic in blocks that lean to enqueue, to dequeue or to neither, sometimes on at most two queues
    task automatic run_random(input int beats);
        int         enq_pct;
        bit         focused;
        logic [2:0] qa;
        logic [2:0] qb;
        in_t        beat;
        enq_pct = 50;
        focused = 1'b0;
        qa      = '0;
        qb      = '0;
        for (int n = 0; n < beats; n++) begin
            if (n % BLOCK_BEATS == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                focused = 1'($urandom_range(1));
                qa      = 3'($urandom_range(7));
                qb      = 3'($urandom_range(7));
            end
            beat.cmd = ($urandom_range(99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            if (focused) begin
                beat.queue_index = $urandom_range(1) ? qa : qb;
            end else begin
                beat.queue_index = 3'($urandom_range(7));
            end
            beat.value = $urandom;
            send_beat(beat);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner beats: empty reads, extreme words, single-entry queues
        send_op(CMD_DEQ, 3'd0, 32'h0000_0000);
        send_op(CMD_ENQ, 3'd0, 32'h8000_0000);
        send_op(CMD_ENQ, 3'd0, 32'h7fff_ffff);
        send_op(CMD_ENQ, 3'd7, 32'h0000_0000);
        send_op(CMD_ENQ, 3'd7, 32'hffff_ffff);
        send_op(CMD_DEQ, 3'd7, 32'hffff_ffff);
        send_op(CMD_DEQ, 3'd7, 32'h0000_0000);
        send_op(CMD_DEQ, 3'd7, 32'h0000_0000);
        send_op(CMD_DEQ, 3'd0, 32'h0000_0000);
        send_op(CMD_DEQ, 3'd0, 32'h0000_0000);
        send_op(CMD_DEQ, 3'd0, 32'h0000_0000);
        send_op(CMD_ENQ, 3'd3, 32'h5555_5555);
        send_op(CMD_ENQ, 3'd5, 32'haaaa_aaaa);
        send_op(CMD_DEQ, 3'd3, 32'h0000_0000);
        send_op(CMD_DEQ, 3'd5, 32'h0000_0000);

        // long result hold-off so the block backs up on its input
        hold_left = HOLD_CYCLES;
        run_random(40);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            run_random(PHASE_BEATS);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d results checked over four idling phases and a result hold-off",
                 sb.checked);
        $display("%0d enqueues dropped on a full store, %0d dequeues of empty queues",
                 sb.dropped, sb.empty_reads);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
